[rtl/core/spfl_pkg.sv]
package spfl_pkg;

  // field widths
  localparam int unsigned OFF_W     = 20;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned BODY_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TOTAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_OFFSET = 2'd2;

  localparam logic [SIZE_W-1:0] SLOT_BYTES_RST  = 13'd16;
  localparam logic [CNT_W-1:0]  SLOT_TOTAL_RST  = 9'd256;
  localparam logic [BODY_W-1:0] BODY_OFFSET_RST = 16'd64;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_REINIT = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_NOTHING = 2'd2,
    ST_BAD_OFF = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_in;
    logic    pop;
    logic    take_fresh;
    logic    take_ram;
    logic    mul;
    logic    add;
    logic    div_start;
    logic    push;
    logic    reinit;
    logic    set_status;
    status_e status;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_e mode;
    logic  stack_nonempty;
    logic  fresh_avail;
    logic  nothing_to_free;
    logic  bad_offset;
    logic  div_done;
    logic  q_in_range;
  } sts_t;

endpackage

[rtl/core/spfl_if.sv]
interface spfl_in_if import spfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [OFF_W-1:0]  slot_offset;

  modport source (output valid, mode, slot_offset, input ready);
  modport sink   (input valid, mode, slot_offset, output ready);
endinterface

interface spfl_out_if import spfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OFF_W-1:0]  alloc_offset;
  logic [1:0]        status;
  logic              is_full;
  logic              is_empty;

  modport source (output valid, alloc_offset, status, is_full, is_empty, input ready);
  modport sink   (input valid, alloc_offset, status, is_full, is_empty, output ready);
endinterface

[rtl/core/slot_page_free_list_allocator.sv]
// Fixed-size slot allocator for one page. Each request transfer carries a
// mode: allocate pops a free slot and answers body_offset + bytes*slot,
// free maps a page offset to (offset - body_offset) / bytes and pushes
// that slot back, reinitialize makes slots 0..count-1 free again (handed out
// in ascending order). Every request yields exactly one response transfer
// with the offset (0 unless an allocate succeeded), a status code and the
// full/empty flags after the step. Freed slots sit in a LIFO stack RAM on
// top of a fresh-slot counter, so a freed slot is the next one handed out.
// One request is worked at a time: an allocate goes through stack RAM read
// (only when it pops a returned slot), then multiply, then add; an accepted
// free waits on the bit-serial divider, which produces one quotient bit per
// clock over the 20-bit offset, then checks the quotient; a failed allocate,
// a free refused before the divide, reinit and unused modes go straight to
// the result register. The block is ready for the next request in the cycle
// after the response is loaded. A new request may be taken while the
// previous response still waits in the output register. Configuration is to
// be written through cfg_we_i / cfg_idx_i / cfg_wdata_i (0 slot bytes, 1
// slot total, 2 body_offset) only while idle; the block itself does not
// enforce it. The stack RAM needs no clearing after reset; only entries
// below the stack depth are ever read.
module slot_page_free_list_allocator import spfl_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  spfl_in_if.sink              req_i,
  spfl_out_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // configuration registers
  logic [SIZE_W-1:0] slot_bytes_q;
  logic [CNT_W-1:0]  slot_total_q;
  logic [BODY_W-1:0] body_offset_q;

  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q  <= SLOT_BYTES_RST;
      slot_total_q  <= SLOT_TOTAL_RST;
      body_offset_q <= BODY_OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOT_BYTES:  slot_bytes_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SLOT_TOTAL:  slot_total_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_BODY_OFFSET: body_offset_q <= cfg_wdata_i[BODY_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // sequencing: accept, dispatch on mode, work, load result register
  spfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stack, fresh counter, divider, multiply-add and result register
  spfl_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_mode_i    (req_i.mode),
    .in_off_i     (req_i.slot_offset),
    .cfg_size_i   (slot_bytes_q),
    .cfg_count_i  (slot_total_q),
    .cfg_body_i   (body_offset_q),
    .out_offset_o (rsp_o.alloc_offset),
    .out_status_o (rsp_o.status),
    .out_full_o   (rsp_o.is_full),
    .out_empty_o  (rsp_o.is_empty)
  );

endmodule

[rtl/core/spfl_ram.sv]
module spfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/spfl_div.sv]
// Restoring divider, one quotient bit per clock.
module spfl_div import spfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OFF_W-1:0]  dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [OFF_W-1:0]  quotient_o
);

  localparam int unsigned CNT_BITS = $clog2(OFF_W);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(OFF_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [SIZE_W:0]     rem_q, rem_d;
  logic [OFF_W-1:0]    quo_q, quo_d;

  logic [SIZE_W:0]     rem_sh;
  logic                ge;

  // remainder stays below the divisor, so the shifted value fits SIZE_W+1 bits
  assign rem_sh = {rem_q[SIZE_W-1:0], quo_q[OFF_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
      quo_d = {quo_q[OFF_W-2:0], ge};
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/spfl_dp.sv]
module spfl_dp import spfl_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        in_mode_i,
  input  logic [OFF_W-1:0]  in_off_i,
  input  logic [SIZE_W-1:0] cfg_size_i,
  input  logic [CNT_W-1:0]  cfg_count_i,
  input  logic [BODY_W-1:0] cfg_body_i,
  output logic [OFF_W-1:0]  out_offset_o,
  output logic [1:0]        out_status_o,
  output logic              out_full_o,
  output logic              out_empty_o
);

  localparam int unsigned SW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned PW = SIZE_W + SW;

  // control state
  logic [CW-1:0]    depth_q, depth_d;
  logic [CW-1:0]    fresh_q, fresh_d;

  // payload
  mode_e            mode_q;
  logic [OFF_W-1:0] off_q;
  logic [SW-1:0]    slot_q;
  logic [PW-1:0]    prod_q;
  logic [OFF_W-1:0] res_off_q;
  status_e          status_q;
  logic [OFF_W-1:0] out_off_q;
  status_e          out_status_q;
  logic             out_full_q;
  logic             out_empty_q;

  logic [CW-1:0]    n;
  logic [CW-1:0]    fresh_left;
  logic [CW:0]      nfree;
  logic [OFF_W-1:0] body_ext;
  logic [OFF_W-1:0] quotient;
  logic             div_done;
  logic [SW-1:0]    ram_rdata;
  logic [31:0]      sum;

  // effective count = min(configured count, MAX_SLOTS)
  assign n = (32'(cfg_count_i) < 32'(MAX_SLOTS)) ? CW'(cfg_count_i) : CW'(MAX_SLOTS);

  assign fresh_left = (fresh_q < n) ? (n - fresh_q) : '0;
  assign nfree      = {1'b0, depth_q} + {1'b0, fresh_left};
  assign body_ext   = OFF_W'(cfg_body_i);
  assign sum        = 32'(prod_q) + 32'(cfg_body_i);

  spfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (off_q - body_ext),
    .divisor_i  (cfg_size_i),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // returned-slot stack; pop reads depth-1, push writes depth
  spfl_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (depth_q[SW-1:0]),
    .wdata_i (quotient[SW-1:0]),
    .raddr_i (SW'(depth_q - 1'b1)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    depth_d = depth_q;
    fresh_d = fresh_q;
    if (cmd_i.reinit) begin
      depth_d = '0;
      fresh_d = '0;
    end else if (cmd_i.pop) begin
      depth_d = depth_q - 1'b1;
    end else if (cmd_i.push) begin
      depth_d = depth_q + 1'b1;
    end else if (cmd_i.take_fresh) begin
      fresh_d = fresh_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fresh_q <= '0;
    end else begin
      depth_q <= depth_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q    <= mode_e'(in_mode_i);
      off_q     <= in_off_i;
      res_off_q <= '0;
      status_q  <= ST_OK;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.take_fresh) begin
      slot_q <= fresh_q[SW-1:0];
    end else if (cmd_i.take_ram) begin
      slot_q <= ram_rdata;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(cfg_size_i) * PW'(slot_q);
    end
    if (cmd_i.add) begin
      res_off_q <= sum[OFF_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_off_q    <= res_off_q;
      out_status_q <= status_q;
      out_full_q   <= (nfree == '0);
      out_empty_q  <= (nfree >= {1'b0, n});
    end
  end

  assign sts_o.mode            = mode_q;
  assign sts_o.stack_nonempty  = (depth_q != '0);
  assign sts_o.fresh_avail     = (fresh_q < n);
  assign sts_o.nothing_to_free = (nfree >= {1'b0, n});
  assign sts_o.bad_offset      = (off_q < body_ext) || (cfg_size_i == '0);
  assign sts_o.div_done        = div_done;
  assign sts_o.q_in_range      = (quotient < OFF_W'(n));

  assign out_offset_o = out_off_q;
  assign out_status_o = out_status_q;
  assign out_full_o   = out_full_q;
  assign out_empty_o  = out_empty_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CW'(MAX_SLOTS))
    else $error("stack depth beyond capacity");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (depth_q < n))
    else $error("push with stack already holding every slot");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (depth_q != '0))
    else $error("pop from empty stack");

  a_fresh_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_fresh |-> (fresh_q < n))
    else $error("fresh slot handed out past the count");

endmodule

[rtl/core/spfl_ctrl.sv]
module spfl_ctrl import spfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_RES  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_RES;
        case (sts_i.mode)
          MODE_ALLOC: begin
            if (sts_i.stack_nonempty) begin
              cmd_o.pop = 1'b1;
              state_d   = S_RD;
            end else if (sts_i.fresh_avail) begin
              cmd_o.take_fresh = 1'b1;
              state_d          = S_MUL;
            end else begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NO_SLOT;
            end
          end
          MODE_FREE: begin
            if (sts_i.nothing_to_free) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOTHING;
            end else if (sts_i.bad_offset) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_OFF;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          MODE_REINIT: begin
            cmd_o.reinit = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        cmd_o.take_ram = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_RES;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.q_in_range) begin
          cmd_o.push = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_BAD_OFF;
        end
        state_d = S_RES;
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_div_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && $past(state_q) == S_DISP) |-> $past(cmd_o.div_start))
    else $error("divide state entered without a start");

  a_rd_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> (state_q == S_RD))
    else $error("popped slot not captured");

endmodule
